// ===== hw/rtl/tkd_pkg.sv =====
package tkd_pkg;

    localparam int COORD_BITS = 10;
    localparam int KEY_BITS   = 9;
    localparam int BYTE_BITS  = 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;
    localparam int QCNT_BITS  = 3;

    localparam logic [COORD_BITS-1:0] ROWS_RESET = COORD_BITS'(24);
    localparam logic [COORD_BITS-1:0] COLS_RESET = COORD_BITS'(80);

    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    localparam logic [KEY_BITS-1:0] KEY_ESC    = 9'd27;
    localparam logic [KEY_BITS-1:0] KEY_CTRL_Q = 9'd17;
    localparam logic [KEY_BITS-1:0] KEY_LEFT   = 9'd256;
    localparam logic [KEY_BITS-1:0] KEY_RIGHT  = 9'd257;
    localparam logic [KEY_BITS-1:0] KEY_UP     = 9'd258;
    localparam logic [KEY_BITS-1:0] KEY_DOWN   = 9'd259;
    localparam logic [KEY_BITS-1:0] KEY_PGUP   = 9'd260;
    localparam logic [KEY_BITS-1:0] KEY_PGDN   = 9'd261;
    localparam logic [KEY_BITS-1:0] KEY_HOME   = 9'd262;
    localparam logic [KEY_BITS-1:0] KEY_END    = 9'd263;
    localparam logic [KEY_BITS-1:0] KEY_DEL    = 9'd264;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
    } t_key_xfer;

endpackage

// ===== hw/rtl/terminal_key_decoder_cursor_top.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] byte_value; tuser[0] command (1 = read timeout)
// m_axis    out        tdata[8:0] key_code, [18:9] cursor_col, [28:19] cursor_row;
//                      tuser[0] quit
// i_cfg     in         index 0 screen_rows, index 1 screen_cols
//
// One transaction per cycle while the key queue is not full; a key passes from
// the parser into the key queue, then through the registered cursor update to m_axis.
// A four-entry key queue separates the parser from the cursor unit; s_axis
// stalls only when that queue is full. ESC prefix bytes give no output.
// Reset is synchronous: parser idle, cursor at 0,0, 24 rows by 80 columns.
module terminal_key_decoder_cursor_top
    import tkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
    input  logic [0:0]            s_axis_tuser,   // [0] command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [8:0] key_code, [18:9] cursor_col,
                                                  // [28:19] cursor_row, [31:29] zero
    output logic [0:0]            m_axis_tuser,   // [0] quit
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    t_key_xfer             w_push;
    t_key_xfer             w_head;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_accept;
    logic [KEY_BITS-1:0]   w_key;
    logic [COORD_BITS-1:0] w_col, w_row;
    logic                  w_quit;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tkd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_timeout (s_axis_tuser[0]),
        .i_byte    (s_axis_tdata),
        .o_push    (w_push)
    );

    tkd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    tkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_key       (w_key),
        .o_col       (w_col),
        .o_row       (w_row),
        .o_quit      (w_quit)
    );

    assign m_axis_tdata = {3'b000, w_row, w_col, w_key};
    assign m_axis_tuser = w_quit;

`ifndef SYNTHESIS
    a_full_implies_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> m_axis_tvalid)
        else $error("key queue full while output register empty");

    a_quit_matches_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_quit == (w_key == KEY_CTRL_Q)))
        else $error("quit flag disagrees with key code");

    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_key <= KEY_DEL))
        else $error("key code out of range");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> w_accept)
        else $error("key queued without an input transaction");
`endif

endmodule

// ===== hw/rtl/tkd_front.sv =====
module tkd_front
    import tkd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_timeout,
    input  logic [BYTE_BITS-1:0] i_byte,
    output t_key_xfer            o_push
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_SEQ  = 2'd2;
    localparam logic [1:0] PH_DIG  = 2'd3;

    localparam logic [BYTE_BITS-1:0] B_ESC   = 8'h1b;
    localparam logic [BYTE_BITS-1:0] B_CSI   = 8'h5b;
    localparam logic [BYTE_BITS-1:0] B_SS3   = 8'h4f;
    localparam logic [BYTE_BITS-1:0] B_TILDE = 8'h7e;
    localparam logic [BYTE_BITS-1:0] B_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] B_NINE  = 8'h39;

    logic [1:0]           r_phase, n_phase;
    logic [BYTE_BITS-1:0] r_first, n_first;
    logic [BYTE_BITS-1:0] r_digit, n_digit;

    function automatic logic [KEY_BITS-1:0] decode_pair(
        input logic [BYTE_BITS-1:0] lead,
        input logic [BYTE_BITS-1:0] b
    );
        logic [KEY_BITS-1:0] k;
        k = KEY_ESC;
        if (lead == B_CSI) begin
            unique case (b)
                8'h41:   k = KEY_UP;
                8'h42:   k = KEY_DOWN;
                8'h43:   k = KEY_RIGHT;
                8'h44:   k = KEY_LEFT;
                8'h48:   k = KEY_HOME;
                8'h46:   k = KEY_END;
                default: k = KEY_ESC;
            endcase
        end else if (lead == B_SS3) begin
            if (b == 8'h48) k = KEY_HOME;
            else if (b == 8'h46) k = KEY_END;
        end
        return k;
    endfunction

    function automatic logic [KEY_BITS-1:0] decode_digit(input logic [BYTE_BITS-1:0] d);
        logic [KEY_BITS-1:0] k;
        unique case (d)
            8'h31, 8'h37: k = KEY_HOME;
            8'h34, 8'h38: k = KEY_END;
            8'h35:        k = KEY_PGUP;
            8'h36:        k = KEY_PGDN;
            8'h33:        k = KEY_DEL;
            default:      k = KEY_ESC;
        endcase
        return k;
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_first      = r_first;
        n_digit      = r_digit;
        o_push.valid = 1'b0;
        o_push.key   = KEY_ESC;
        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_timeout) begin
                        if (i_byte == B_ESC) begin
                            n_phase = PH_ESC;
                        end else begin
                            o_push.valid = 1'b1;
                            o_push.key   = {1'b0, i_byte};
                        end
                    end
                end
                PH_ESC: begin
                    if (i_timeout) begin
                        o_push.valid = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_first = i_byte;
                        n_phase = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    if (i_timeout) begin
                        o_push.valid = 1'b1;
                        n_phase      = PH_IDLE;
                    end else if (r_first == B_CSI && i_byte >= B_ZERO && i_byte <= B_NINE) begin
                        n_digit = i_byte;
                        n_phase = PH_DIG;
                    end else begin
                        o_push.valid = 1'b1;
                        o_push.key   = decode_pair(r_first, i_byte);
                        n_phase      = PH_IDLE;
                    end
                end
                default: begin
                    o_push.valid = 1'b1;
                    if (!i_timeout && i_byte == B_TILDE) o_push.key = decode_digit(r_digit);
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= '0;
            r_digit <= '0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_digit <= n_digit;
        end
    end

endmodule

// ===== hw/rtl/tkd_queue.sv =====
module tkd_queue
    import tkd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_key_xfer i_push,
    input  logic      i_pop,
    output t_key_xfer o_head,
    output logic      o_full
);

    logic [KEY_BITS-1:0]  r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;
    logic                 w_do_pop;

    assign o_full       = (r_count == QCNT_BITS'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.key   = r_mem[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) n_wr_ptr = r_wr_ptr + 1'b1;
        if (w_do_pop) n_rd_ptr = r_rd_ptr + 1'b1;
        if (i_push.valid && !w_do_pop) n_count = r_count + 1'b1;
        else if (!i_push.valid && w_do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wr_ptr] <= i_push.key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/tkd_back.sv =====
module tkd_back
    import tkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  t_key_xfer             i_head,
    output logic                  o_pop,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row,
    output logic                  o_quit
);

    logic [COORD_BITS-1:0] r_rows, r_cols;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic                  r_out_valid;
    logic [KEY_BITS-1:0]   r_out_key;
    logic [COORD_BITS-1:0] r_out_col, r_out_row;
    logic                  r_out_quit;
    logic [COORD_BITS:0]   w_col_inc, w_row_inc;
    logic [COORD_BITS-1:0] w_last_col, w_last_row;

    assign o_pop      = i_head.valid && (!r_out_valid || i_out_ready);
    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_last_col = (r_cols == '0) ? '0 : r_cols - 1'b1;
    assign w_last_row = (r_rows == '0) ? '0 : r_rows - 1'b1;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_head.key)
            KEY_LEFT:  if (r_col != '0) n_col = r_col - 1'b1;
            KEY_RIGHT: if (w_col_inc < {1'b0, r_cols}) n_col = w_col_inc[COORD_BITS-1:0];
            KEY_UP:    if (r_row != '0) n_row = r_row - 1'b1;
            KEY_DOWN:  if (w_row_inc < {1'b0, r_rows}) n_row = w_row_inc[COORD_BITS-1:0];
            KEY_PGUP:  n_row = '0;
            KEY_PGDN:  n_row = w_last_row;
            KEY_HOME:  n_col = '0;
            KEY_END:   n_col = w_last_col;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (o_pop) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_key  <= i_head.key;
            r_out_col  <= n_col;
            r_out_row  <= n_row;
            r_out_quit <= (i_head.key == KEY_CTRL_Q);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key       = r_out_key;
    assign o_col       = r_out_col;
    assign o_row       = r_out_row;
    assign o_quit      = r_out_quit;

endmodule

// ===== bench/tb_terminal_key_decoder_cursor_top.sv =====
`timescale 1ns / 1ps

module tb_terminal_key_decoder_cursor_top;
    import tkd_pkg::*;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam logic [7:0] CSI_FINALS [6]   = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
    localparam logic [7:0] TILDE_DIGITS [7] = '{CH_1, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8};

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int N_PLAN          = 8;
    localparam int PRESSURE_PHASE  = 2;
    localparam int HOLD_OFF_CYCLES = 60;

    localparam logic [COORD_BITS-1:0] PLAN_ROWS [N_PLAN] =
        '{10'd24, 10'd1, 10'd1023, 10'd3, 10'd0, 10'd1023, 10'd2, 10'd7};
    localparam logic [COORD_BITS-1:0] PLAN_COLS [N_PLAN] =
        '{10'd80, 10'd1, 10'd1023, 10'd5, 10'd0, 10'd2, 10'd1023, 10'd9};

    typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_LEAD, PH_DIGIT} t_parse_phase;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  quit;
    } t_key_report;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic        typed;
        t_key_report want;
    } t_stim_row;

    localparam t_key_report NO_REPORT = '0;

    localparam t_stim_row OPENING_ROWS [25] = '{
        '{CMD_BYTE,    8'h00,    1'b1, '{9'd0,       10'd0,  10'd0,  1'b0}},
        '{CMD_BYTE,    8'hFF,    1'b1, '{9'd255,     10'd0,  10'd0,  1'b0}},
        '{CMD_BYTE,    8'h11,    1'b1, '{KEY_CTRL_Q, 10'd0,  10'd0,  1'b1}},
        '{CMD_TIMEOUT, 8'h00,    1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_O,     1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_F,     1'b1, '{KEY_END,    10'd79, 10'd0,  1'b0}},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_LBRKT, 1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_6,     1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_TILDE, 1'b1, '{KEY_PGDN,   10'd79, 10'd23, 1'b0}},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_LBRKT, 1'b0, NO_REPORT},
        '{CMD_TIMEOUT, 8'hFF,    1'b1, '{KEY_ESC,    10'd79, 10'd23, 1'b0}},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_LBRKT, 1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_NINE,  1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_TILDE, 1'b1, '{KEY_ESC,    10'd79, 10'd23, 1'b0}},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_O,     1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_A,     1'b1, '{KEY_ESC,    10'd79, 10'd23, 1'b0}},
        '{CMD_BYTE,    CH_ESC,   1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_LBRKT, 1'b0, NO_REPORT},
        '{CMD_BYTE,    CH_3,     1'b0, NO_REPORT},
        '{CMD_BYTE,    8'h78,    1'b1, '{KEY_ESC,    10'd79, 10'd23, 1'b0}}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [0:0]            i_cfg_index   = CFG_ROWS;
    logic [COORD_BITS-1:0] i_cfg_data    = '0;

    t_parse_phase          ph        = PH_IDLE;
    logic [7:0]            seq_lead  = '0;
    logic [7:0]            seq_digit = '0;
    logic [COORD_BITS-1:0] cur_col   = '0;
    logic [COORD_BITS-1:0] cur_row   = '0;
    logic [COORD_BITS-1:0] scr_rows  = ROWS_RESET;
    logic [COORD_BITS-1:0] scr_cols  = COLS_RESET;

    t_key_report expected_reports [$];
    int          mismatch_count = 0;
    int          items_fed      = 0;
    int          idle_cycles    = 0;
    int          rx_hold_req    = 0;
    bit          calm           = 1'b0;
    bit          burst          = 1'b0;

    terminal_key_decoder_cursor_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predict_key(input logic cmd, input logic [7:0] b,
                                        output bit produced, output t_key_report rep);
        logic [KEY_BITS-1:0] key;
        produced = 1'b0;
        rep      = '0;
        key      = KEY_ESC;
        case (ph)
            PH_IDLE: begin
                if (cmd == CMD_TIMEOUT) return;
                if (b == CH_ESC) begin
                    ph = PH_ESC;
                    return;
                end
                key = {1'b0, b};
            end
            PH_ESC: begin
                if (cmd == CMD_BYTE) begin
                    seq_lead = b;
                    ph = PH_LEAD;
                    return;
                end
            end
            PH_LEAD: begin
                if (cmd == CMD_BYTE) begin
                    if (seq_lead == CH_LBRKT && b >= CH_ZERO && b <= CH_NINE) begin
                        seq_digit = b;
                        ph = PH_DIGIT;
                        return;
                    end
                    if (seq_lead == CH_LBRKT) begin
                        case (b)
                            CH_A:    key = KEY_UP;
                            CH_B:    key = KEY_DOWN;
                            CH_C:    key = KEY_RIGHT;
                            CH_D:    key = KEY_LEFT;
                            CH_H:    key = KEY_HOME;
                            CH_F:    key = KEY_END;
                            default: key = KEY_ESC;
                        endcase
                    end else if (seq_lead == CH_O && b == CH_H) begin
                        key = KEY_HOME;
                    end else if (seq_lead == CH_O && b == CH_F) begin
                        key = KEY_END;
                    end
                end
            end
            default: begin
                if (cmd == CMD_BYTE && b == CH_TILDE) begin
                    case (seq_digit)
                        CH_1, CH_7: key = KEY_HOME;
                        CH_4, CH_8: key = KEY_END;
                        CH_5:       key = KEY_PGUP;
                        CH_6:       key = KEY_PGDN;
                        CH_3:       key = KEY_DEL;
                        default:    key = KEY_ESC;
                    endcase
                end
            end
        endcase

        ph = PH_IDLE;
        case (key)
            KEY_LEFT:  if (cur_col != '0) cur_col = cur_col - 1'b1;
            KEY_RIGHT: if ({1'b0, cur_col} + 11'd1 < {1'b0, scr_cols}) cur_col = cur_col + 1'b1;
            KEY_UP:    if (cur_row != '0) cur_row = cur_row - 1'b1;
            KEY_DOWN:  if ({1'b0, cur_row} + 11'd1 < {1'b0, scr_rows}) cur_row = cur_row + 1'b1;
            KEY_PGUP:  cur_row = '0;
            KEY_PGDN:  cur_row = (scr_rows == '0) ? '0 : scr_rows - 1'b1;
            KEY_HOME:  cur_col = '0;
            KEY_END:   cur_col = (scr_cols == '0) ? '0 : scr_cols - 1'b1;
            default: ;
        endcase
        produced = 1'b1;
        rep.key  = key;
        rep.col  = cur_col;
        rep.row  = cur_row;
        rep.quit = (key == KEY_CTRL_Q);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b,
                             input bit typed, input t_key_report want);
        int          gap;
        bit          produced;
        t_key_report rep;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!(cmd == CMD_TIMEOUT && ph == PH_IDLE)) items_fed++;
        predict_key(cmd, b, produced, rep);
        if (produced) expected_reports.push_back(typed ? want : rep);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, 1'b0, NO_REPORT);
    endtask

    task automatic send_random_sequence();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_byte(KEY_CTRL_Q[7:0]);
        end else if (r < 22) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (r < 68) begin
            send_byte(CH_ESC);
            k = $urandom_range(0, 14);
            if (k < 6) begin
                send_byte(CH_LBRKT);
                send_byte(CSI_FINALS[k]);
            end else if (k < 8) begin
                send_byte(CH_O);
                send_byte((k == 6) ? CH_H : CH_F);
            end else begin
                send_byte(CH_LBRKT);
                send_byte(TILDE_DIGITS[k-8]);
                send_byte(CH_TILDE);
            end
        end else if (r < 78) begin
            k = $urandom_range(0, 3);
            if (k > 0) send_byte(CH_ESC);
            if (k > 1) send_byte(CH_LBRKT);
            if (k > 2) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            send_item(CMD_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        end else begin
            send_byte(CH_ESC);
            if ($urandom_range(0, 1) == 1) begin
                send_byte(CH_LBRKT);
                send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
                send_byte(($urandom_range(0, 1) == 1) ? CH_TILDE : 8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // wait out every expected key
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        wait (expected_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_screen(input logic [COORD_BITS-1:0] rows,
                                input logic [COORD_BITS-1:0] cols);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows;
        @(negedge i_clk);
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        scr_rows = rows;
        scr_cols = cols;
    endtask

    task automatic report_mismatch(input string what, input t_key_report want,
                                   input t_key_report got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: expected key=%0d col=%0d row=%0d quit=%0b, ",
                      "got key=%0d col=%0d row=%0d quit=%0b"},
                     $realtime, what, want.key, want.col, want.row, want.quit,
                     got.key, got.col, got.row, got.quit);
    endtask

    initial begin
        int p;
        int seq_count;
        seq_count = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (OPENING_ROWS[i])
            send_item(OPENING_ROWS[i].cmd, OPENING_ROWS[i].data,
                      OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

        for (p = 0; p < N_PLAN; p++) begin
            if (p > 0) begin
                drain_block();
                write_screen(PLAN_ROWS[p], PLAN_COLS[p]);
            end
            items_fed = 0;
            if (p == PRESSURE_PHASE) begin
                // hold the output side and feed a burst of sequences so that the input stalls
                rx_hold_req = HOLD_OFF_CYCLES;
                burst = 1'b1;
                repeat (12) send_random_sequence();
                burst = 1'b0;
                drain_block();
            end
            while (items_fed < ITEMS_PER_PHASE) begin
                if (seq_count % 16 == 0) calm = ($urandom_range(0, 3) == 0);
                send_random_sequence();
                seq_count++;
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        wait (expected_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_terminal_key_decoder_cursor_top OK");
        else
            $display("tb_terminal_key_decoder_cursor_top NOT OK");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                           : $urandom_range(1, 3);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : key_monitor
        t_key_report got;
        t_key_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.key  = m_axis_tdata[8:0];
            got.col  = m_axis_tdata[18:9];
            got.row  = m_axis_tdata[28:19];
            got.quit = m_axis_tuser[0];
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected key", NO_REPORT, got);
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) report_mismatch("key mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_terminal_key_decoder_cursor_top NOT OK");
            $finish;
        end
    end

endmodule
